FILE: src/ktil_pkg.sv
// Shared types and codes for the keyed table.
`timescale 1ns / 1ps

package ktil_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned KeyW     = 240;
  localparam int unsigned ValW     = 88;
  localparam int unsigned StatusW  = 3;

  localparam logic [StatusW-1:0] StInserted = 3'd0;
  localparam logic [StatusW-1:0] StUpdated  = 3'd1;
  localparam logic [StatusW-1:0] StFull     = 3'd2;
  localparam logic [StatusW-1:0] StHit      = 3'd3;
  localparam logic [StatusW-1:0] StMiss     = 3'd4;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic [KeyW-1:0] key;
  } entry_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ValW-1:0]    value;
  } res_t;

endpackage

FILE: src/ktil_mem.sv
// Entry store: one write port, one registered read port.
`timescale 1ns / 1ps

module ktil_mem #(
  parameter int unsigned CAPACITY = ktil_pkg::Capacity,
  parameter int unsigned AddrW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  ktil_pkg::entry_t wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output ktil_pkg::entry_t rdata_o
);

  ktil_pkg::entry_t mem_q [CAPACITY];
  ktil_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/ktil_ctrl.sv
// Search sequencer: walks stored entries through one key comparator.
`timescale 1ns / 1ps

module ktil_ctrl #(
  parameter int unsigned CAPACITY = ktil_pkg::Capacity,
  parameter int unsigned AddrW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int unsigned CntW     = $clog2(CAPACITY + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             lookup_i,
  input  ktil_pkg::entry_t item_i,
  output logic             idle_o,
  output logic             done_o,
  output ktil_pkg::res_t   res_o,
  input  logic             res_take_i,
  output logic             we_o,
  output logic [AddrW-1:0] waddr_o,
  output ktil_pkg::entry_t wdata_o,
  output logic             re_o,
  output logic [AddrW-1:0] raddr_o,
  input  ktil_pkg::entry_t rdata_i
);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SScan = 2'd1;
  localparam logic [1:0] SDone = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             rvalid_q, rvalid_d;
  logic [AddrW-1:0] rptr_q;
  logic             lookup_q;
  ktil_pkg::entry_t item_q;
  ktil_pkg::res_t   res_q, res_d;
  logic             issue, match, finish;

  assign issue = idx_q < cnt_q;
  assign match = rvalid_q && (rdata_i.key == item_q.key);

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    rvalid_d = 1'b0;
    res_d    = res_q;
    finish   = 1'b0;
    we_o     = 1'b0;
    waddr_o  = rptr_q;
    re_o     = 1'b0;
    case (state_q)
      SIdle: begin
        if (start_i) begin
          idx_d   = '0;
          state_d = SScan;
        end
      end
      SScan: begin
        if (match) begin
          finish = 1'b1;
          if (lookup_q) begin
            res_d.status = ktil_pkg::StHit;
            res_d.value  = rdata_i.value;
          end else begin
            we_o         = 1'b1;
            res_d.status = ktil_pkg::StUpdated;
            res_d.value  = '0;
          end
        end else if (!issue && !rvalid_q) begin
          finish      = 1'b1;
          res_d.value = '0;
          if (lookup_q) begin
            res_d.status = ktil_pkg::StMiss;
          end else if (cnt_q == CntW'(CAPACITY)) begin
            res_d.status = ktil_pkg::StFull;
          end else begin
            we_o         = 1'b1;
            waddr_o      = cnt_q[AddrW-1:0];
            cnt_d        = cnt_q + 1'b1;
            res_d.status = ktil_pkg::StInserted;
          end
        end
        if (finish) begin
          state_d = SDone;
        end else if (issue) begin
          re_o     = 1'b1;
          rvalid_d = 1'b1;
          idx_d    = idx_q + 1'b1;
        end
      end
      SDone: begin
        if (res_take_i) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      idx_q    <= '0;
      cnt_q    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      rvalid_q <= rvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (re_o) begin
      rptr_q <= idx_q[AddrW-1:0];
    end
    if (start_i && state_q == SIdle) begin
      item_q   <= item_i;
      lookup_q <= lookup_i;
    end
  end

  assign raddr_o = idx_q[AddrW-1:0];
  assign wdata_o = item_q;
  assign idle_o  = state_q == SIdle;
  assign done_o  = state_q == SDone;
  assign res_o   = res_q;

endmodule

FILE: src/keyed_table_insert_lookup.sv
// Top level of the keyed table with insert, update and lookup.
//
// Request channel (in_valid_i / in_ready_o): one item per request, carrying
// the request type, a 30-byte zero-padded key and an 11-byte value. Key and
// value end at their first zero byte; later bytes count as zero.
// Result channel (out_valid_o / out_ready_i): exactly one item per request,
// with a status and, on a lookup hit, the stored value (zero otherwise).
// After acceptance the sequencer reads the n stored entries (n at most
// CAPACITY) one entry a cycle from the single read port of the entry store,
// checks each in the shared key comparator and stops at the first match.
// One request is in work at a time; in_ready_o is high only while idle, from
// the cycle after the result is loaded.
// A finished result sits in the output register; while the receiver stalls
// the next request may be accepted and searched, and it waits for the
// output register to free before finishing.
// Reset empties the table at once (entry count to zero); store contents
// need no clearing.
`timescale 1ns / 1ps

module keyed_table_insert_lookup #(
  parameter int unsigned CAPACITY = ktil_pkg::Capacity
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic         req_type_i,
  input  logic [63:0]  key_word0_i,
  input  logic [63:0]  key_word1_i,
  input  logic [63:0]  key_word2_i,
  input  logic [47:0]  key_word3_i,
  input  logic [63:0]  value_low_i,
  input  logic [23:0]  value_high_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [2:0]   status_o,
  output logic [63:0]  out_value_low_o,
  output logic [23:0]  out_value_high_o
);

  localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);

  function automatic logic [ktil_pkg::KeyW-1:0] clr_key(input logic [ktil_pkg::KeyW-1:0] w);
    logic                        ended;
    logic [ktil_pkg::KeyW-1:0]   r;
    ended = 1'b0;
    r     = w;
    for (int b = 0; b < ktil_pkg::KeyW / 8; b++) begin
      if (ended) begin
        r[b*8 +: 8] = 8'h00;
      end else if (w[b*8 +: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [ktil_pkg::ValW-1:0] clr_val(input logic [ktil_pkg::ValW-1:0] w);
    logic                        ended;
    logic [ktil_pkg::ValW-1:0]   r;
    ended = 1'b0;
    r     = w;
    for (int b = 0; b < ktil_pkg::ValW / 8; b++) begin
      if (ended) begin
        r[b*8 +: 8] = 8'h00;
      end else if (w[b*8 +: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return r;
  endfunction

  ktil_pkg::entry_t item;
  ktil_pkg::entry_t wdata, rdata;
  ktil_pkg::res_t   res;
  logic             idle, done, res_take, in_acc;
  logic             we, re;
  logic [AddrW-1:0] waddr, raddr;
  logic             out_valid_q;
  ktil_pkg::res_t   out_q;

  assign item.key   = clr_key({key_word3_i, key_word2_i, key_word1_i, key_word0_i});
  assign item.value = clr_val({value_high_i, value_low_i});

  assign in_ready_o = idle;
  assign in_acc     = in_valid_i && idle;
  assign res_take   = done && (!out_valid_q || out_ready_i);

  ktil_ctrl #(
    .CAPACITY (CAPACITY),
    .AddrW    (AddrW),
    .CntW     (CntW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc),
    .lookup_i   (req_type_i),
    .item_i     (item),
    .idle_o     (idle),
    .done_o     (done),
    .res_o      (res),
    .res_take_i (res_take),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .re_o       (re),
    .raddr_o    (raddr),
    .rdata_i    (rdata)
  );

  ktil_mem #(
    .CAPACITY (CAPACITY),
    .AddrW    (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign out_value_low_o  = out_q.value[63:0];
  assign out_value_high_o = out_q.value[ktil_pkg::ValW-1:64];

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("ready high right after an accepted item");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_take |=> out_valid_o)
    else $error("finished result not presented");

  a_value_zero_unless_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ktil_pkg::StHit) |->
      (out_value_low_o == '0 && out_value_high_o == '0))
    else $error("non-zero value on a result other than a hit");
`endif

endmodule

FILE: sim/keyed_table_insert_lookup_tb.sv
// Testbench for the keyed table: directed and random requests checked against a shadow table.
`timescale 1ns / 1ps

module keyed_table_insert_lookup_tb;

  localparam logic        ReqAdd    = 1'b0;
  localparam logic        ReqLookup = 1'b1;
  localparam int          KeyBytes  = 30;
  localparam int          ValBytes  = 11;
  localparam int          RandItems = 1750;
  localparam int unsigned KeyW      = ktil_pkg::KeyW;
  localparam int unsigned ValW      = ktil_pkg::ValW;
  localparam int unsigned Capacity  = ktil_pkg::Capacity;

  typedef ktil_pkg::res_t res_t;

  typedef struct packed {
    logic            lookup;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] val;
    logic            hold;
  } request_t;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic        in_ready_o;
  logic        req_type_i       = ReqAdd;
  logic [63:0] key_word0_i      = '0;
  logic [63:0] key_word1_i      = '0;
  logic [63:0] key_word2_i      = '0;
  logic [47:0] key_word3_i      = '0;
  logic [63:0] value_low_i      = '0;
  logic [23:0] value_high_i     = '0;
  logic        out_valid_o;
  logic        out_ready_i      = 1'b0;
  logic [2:0]  status_o;
  logic [63:0] out_value_low_o;
  logic [23:0] out_value_high_o;

  request_t        requests_todo[$];
  request_t        cur_req;
  res_t            answers_due[$];
  logic [KeyW-1:0] key_pool[$];
  logic [KeyW-1:0] shadow_key[Capacity];
  logic [ValW-1:0] shadow_val[Capacity];
  int              shadow_fill  = 0;
  int              mismatch_cnt = 0;
  int              gap_left     = 0;
  int              stall_left   = 0;
  bit              calm         = 1'b0;

  keyed_table_insert_lookup uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .key_word0_i     (key_word0_i),
    .key_word1_i     (key_word1_i),
    .key_word2_i     (key_word2_i),
    .key_word3_i     (key_word3_i),
    .value_low_i     (value_low_i),
    .value_high_i    (value_high_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .out_value_low_o (out_value_low_o),
    .out_value_high_o(out_value_high_o)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  // bytes from the first zero byte on count as zero
  function automatic logic [KeyW-1:0] cut_at_nul(input logic [KeyW-1:0] s, input int nbytes);
    logic [KeyW-1:0] r;
    bit              ended;
    r     = '0;
    ended = 1'b0;
    for (int b = 0; b < nbytes; b++) begin
      if (s[b*8 +: 8] == 8'h00) ended = 1'b1;
      if (!ended) r[b*8 +: 8] = s[b*8 +: 8];
    end
    return r;
  endfunction

  task automatic predict_request(input request_t r);
    logic [KeyW-1:0] k;
    logic [KeyW-1:0] v;
    res_t            ans;
    int              hit;
    k   = cut_at_nul(r.key, KeyBytes);
    v   = cut_at_nul({{(KeyW-ValW){1'b0}}, r.val}, ValBytes);
    ans = '0;
    hit = -1;
    for (int i = 0; i < shadow_fill; i++) begin
      if (hit < 0 && shadow_key[i] == k) hit = i;
    end
    if (hit >= 0) begin
      if (r.lookup) begin
        ans.status = ktil_pkg::StHit;
        ans.value  = shadow_val[hit];
      end else begin
        shadow_val[hit] = v[ValW-1:0];
        ans.status      = ktil_pkg::StUpdated;
      end
    end else if (r.lookup) begin
      ans.status = ktil_pkg::StMiss;
    end else if (shadow_fill >= Capacity) begin
      ans.status = ktil_pkg::StFull;
    end else begin
      shadow_key[shadow_fill] = k;
      shadow_val[shadow_fill] = v[ValW-1:0];
      shadow_fill++;
      ans.status = ktil_pkg::StInserted;
    end
    answers_due.push_back(ans);
  endtask

  function automatic int rand_len(input int nbytes);
    if ($urandom_range(0, 5) == 0) return nbytes;
    return $urandom_range(0, nbytes);
  endfunction

  // len non-zero bytes, a terminator, then junk or zeros
  function automatic logic [KeyW-1:0] rand_string(input int nbytes, input int len, input bit junk);
    logic [KeyW-1:0] s;
    s = '0;
    for (int b = 0; b < nbytes; b++) begin
      if (b < len) s[b*8 +: 8] = 8'($urandom_range(1, 255));
      else if (b > len && junk) s[b*8 +: 8] = 8'($urandom_range(0, 255));
    end
    return s;
  endfunction

  function automatic logic [KeyW-1:0] rand_value();
    return rand_string(ValBytes, rand_len(ValBytes), 1'($urandom_range(0, 1)));
  endfunction

  function automatic logic [KeyW-1:0] rejunk(input logic [KeyW-1:0] s);
    bit ended;
    ended = 1'b0;
    for (int b = 0; b < KeyBytes; b++) begin
      if (ended) s[b*8 +: 8] = 8'($urandom_range(0, 255));
      else if (s[b*8 +: 8] == 8'h00) ended = 1'b1;
    end
    return s;
  endfunction

  // flip one byte inside the key proper
  function automatic logic [KeyW-1:0] near_miss(input logic [KeyW-1:0] s);
    int len;
    int idx;
    len = KeyBytes;
    for (int b = KeyBytes - 1; b >= 0; b--) begin
      if (s[b*8 +: 8] == 8'h00) len = b;
    end
    if (len == 0) begin
      s[7:0] = 8'($urandom_range(1, 255));
    end else begin
      idx = $urandom_range(0, len - 1);
      s[idx*8 +: 8] = s[idx*8 +: 8] ^ 8'($urandom_range(1, 255));
    end
    return s;
  endfunction

  function automatic logic [KeyW-1:0] pool_pick();
    int n;
    n = key_pool.size();
    if (n > Capacity && $urandom_range(0, 9) < 7) n = Capacity;
    return key_pool[$urandom_range(0, n - 1)];
  endfunction

  task automatic queue_item(input logic op, input logic [KeyW-1:0] key,
                            input logic [KeyW-1:0] val, input bit hold);
    request_t r;
    r.lookup = op;
    r.key    = key;
    r.val    = val[ValW-1:0];
    r.hold   = hold;
    requests_todo.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      req_type_i   <= ReqAdd;
      key_word0_i  <= '0;
      key_word1_i  <= '0;
      key_word2_i  <= '0;
      key_word3_i  <= '0;
      value_low_i  <= '0;
      value_high_i <= '0;
      gap_left = 0;
    end else begin : drive
      bit       slot_free;
      request_t nxt;
      slot_free = !in_valid_i || in_ready_o;
      if (in_valid_i && in_ready_o) begin
        predict_request(cur_req);
        if (!calm && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 14);
      end
      if (slot_free) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (requests_todo.size() != 0 &&
                     !(requests_todo[0].hold && (answers_due.size() != 0 || out_valid_o))) begin
          nxt          = requests_todo.pop_front();
          cur_req      = nxt;
          in_valid_i   <= 1'b1;
          req_type_i   <= nxt.lookup;
          key_word0_i  <= nxt.key[63:0];
          key_word1_i  <= nxt.key[127:64];
          key_word2_i  <= nxt.key[191:128];
          key_word3_i  <= nxt.key[239:192];
          value_low_i  <= nxt.val[63:0];
          value_high_i <= nxt.val[87:64];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      calm <= requests_todo.size() < 150;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else begin : watch
      res_t want;
      if (out_valid_o && out_ready_i) begin
        if (answers_due.size() == 0) begin
          $error("result item with no request outstanding: status %0d", status_o);
          mismatch_cnt++;
        end else begin
          want = answers_due.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            mismatch_cnt++;
          end
          if (out_value_low_o !== want.value[63:0]) begin
            $error("out_value_low: expected %h, got %h", want.value[63:0], out_value_low_o);
            mismatch_cnt++;
          end
          if (out_value_high_o !== want.value[87:64]) begin
            $error("out_value_high: expected %h, got %h", want.value[87:64], out_value_high_o);
            mismatch_cnt++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [KeyW-1:0] ones;
    logic [KeyW-1:0] k;
    logic [KeyW-1:0] v;
    int              pick;
    bit              hold;
    ones = '1;

    queue_item(ReqLookup, ones, ones, 1'b0);       // empty table
    queue_item(ReqAdd, ones, ones, 1'b0);          // key and value with no terminator
    queue_item(ReqLookup, ones, '0, 1'b0);
    queue_item(ReqAdd, '0, '0, 1'b0);              // empty key
    queue_item(ReqLookup, '0, ones, 1'b0);         // value fields ignored on lookup
    k = ones;
    k[7:0]  = 8'h41;
    k[15:8] = 8'h00;
    v = ones;
    v[15:8] = 8'h00;
    queue_item(ReqAdd, k, v, 1'b0);                // junk after terminator
    queue_item(ReqLookup, rejunk(k), ones, 1'b0);
    k[239:16] = '0;
    queue_item(ReqLookup, k, '0, 1'b0);
    queue_item(ReqAdd, k, 240'h5a, 1'b0);          // update
    queue_item(ReqLookup, rejunk(k), '0, 1'b0);
    k = ones;
    k[239:232] = 8'hfe;
    queue_item(ReqAdd, k, 240'h0123456789abcdef_fedcba, 1'b0);
    queue_item(ReqLookup, k, '0, 1'b0);
    k[239:232] = 8'h00;
    queue_item(ReqLookup, k, '0, 1'b0);
    queue_item(ReqAdd, k, 240'h80, 1'b0);
    queue_item(ReqLookup, k, '0, 1'b0);
    queue_item(ReqAdd, ones, 240'h1, 1'b0);
    queue_item(ReqLookup, ones, '0, 1'b0);
    key_pool.push_back(ones);
    key_pool.push_back('0);

    for (int i = 0; i < RandItems; i++) begin
      pick = $urandom_range(0, 99);
      hold = (i == 600 || i == 1200);
      if (pick < 20) begin
        k = rand_string(KeyBytes, rand_len(KeyBytes), 1'($urandom_range(0, 1)));
        key_pool.push_back(k);
        queue_item(ReqAdd, k, rand_value(), hold);
      end else begin
        k = pool_pick();
        if ($urandom_range(0, 1) == 1) k = rejunk(k);
        if (pick < 45) queue_item(ReqAdd, k, rand_value(), hold);
        else if (pick < 80) queue_item(ReqLookup, k, rand_value(), hold);
        else if (pick < 90) queue_item(ReqLookup, near_miss(k), rand_value(), hold);
        else queue_item(ReqLookup, rand_string(KeyBytes, rand_len(KeyBytes), 1'b1),
                        rand_value(), hold);
      end
    end

    while (requests_todo.size() != 0 || in_valid_i) @(posedge clk_i);
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (mismatch_cnt == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
